// ===== src/tcm_pkg.sv =====
// Package with the shared types, character codes and color tables of the markup parser.
`timescale 1ns / 1ps
`default_nettype none

package tcm_pkg;

  // Character codes with a meaning in the markup.
  localparam logic [7:0] CharCaret   = 8'h5E;  // '^'
  localparam logic [7:0] CharBracket = 8'h5B;  // '['
  localparam logic [7:0] CharClose   = 8'h5D;  // ']'

  // Color that each text starts with after reset: opaque white.
  localparam logic [31:0] ColorResetValue = 32'hFFFF_FFFF;

  // Result of a named color lookup.
  typedef struct packed {
    logic        hit;
    logic [31:0] rgba;
  } named_color_t;

  // Result of a hex digit decode.
  typedef struct packed {
    logic       hit;
    logic [3:0] value;
  } hex_digit_t;

  // Maps a color letter to its opaque RGBA value, red in the top byte.
  function automatic named_color_t named_color(input logic [7:0] ch);
    named_color_t res;
    res.hit = 1'b1;
    case (ch)
      8'h72:   res.rgba = 32'hFF00_00FF;  // r
      8'h67:   res.rgba = 32'h00FF_00FF;  // g
      8'h62:   res.rgba = 32'h0000_FFFF;  // b
      8'h63:   res.rgba = 32'h00FF_FFFF;  // c
      8'h79:   res.rgba = 32'hFFFF_00FF;  // y
      8'h6D:   res.rgba = 32'hFF00_FFFF;  // m
      8'h6B:   res.rgba = 32'h0000_00FF;  // k
      8'h77:   res.rgba = 32'hFFFF_FFFF;  // w
      default: begin
        res.hit  = 1'b0;
        res.rgba = 32'h0000_0000;
      end
    endcase
    return res;
  endfunction

  // Decodes an ASCII hex digit in either case.
  function automatic hex_digit_t hex_digit(input logic [7:0] ch);
    hex_digit_t res;
    res.hit   = 1'b0;
    res.value = 4'h0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      res.hit   = 1'b1;
      res.value = 4'(ch - 8'h30);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      res.hit   = 1'b1;
      res.value = 4'(ch - 8'h57);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      res.hit   = 1'b1;
      res.value = 4'(ch - 8'h37);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/tcm_in_if.sv =====
// Stream interface that carries text characters into the parser.
`timescale 1ns / 1ps
`default_nettype none

interface tcm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       text_end;

  modport source (output valid, output char_code, output text_end, input ready);
  modport sink   (input valid, input char_code, input text_end, output ready);
endinterface

`default_nettype wire

// ===== src/tcm_out_if.sv =====
// Stream interface that carries colored glyph results out of the parser.
`timescale 1ns / 1ps
`default_nettype none

interface tcm_out_if;
  logic       valid;
  logic       ready;
  logic       glyph_valid;
  logic [7:0] glyph_code;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       end_flag;

  modport source (output valid, output glyph_valid, output glyph_code, output red,
                  output green, output blue, output alpha, output end_flag,
                  input ready);
  modport sink   (input valid, input glyph_valid, input glyph_code, input red,
                  input green, input blue, input alpha, input end_flag,
                  output ready);
endinterface

`default_nettype wire

// ===== src/text_color_markup_parser_core.sv =====
// Top level of the caret color markup parser: parse state, color state and result register.
//
//  Channel   Direction  Handshake          Beat contents
//  in_i      sink       valid / ready      char_code, text_end
//  out_o     source     valid / ready      glyph_valid, glyph_code, red, green, blue,
//                                          alpha, end_flag
//  cfg       write      cfg_we_i           cfg_wdata_i (default color, RGBA)
//
// Each input beat is parsed in the cycle it is accepted; its result appears in the
// output register on the next cycle. One beat is taken every cycle, bounded only by
// the single output register: a new beat enters whenever that register is empty or
// is being drained in the same cycle. Reset empties the output register, sets the
// parse phase to plain text and loads opaque white as default and current color.
`timescale 1ns / 1ps
`default_nettype none

module text_color_markup_parser_core
  import tcm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  tcm_in_if.sink           in_i,
  tcm_out_if.source        out_o
);

  // Parse phase codes.
  localparam logic [1:0] PhasePlain  = 2'd0;
  localparam logic [1:0] PhaseEscape = 2'd1;
  localparam logic [1:0] PhaseDigits = 2'd2;
  localparam logic [1:0] PhaseSkip   = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [31:0] color_q, color_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] default_q;

  logic        out_valid_q;
  logic        glyph_valid_q, glyph_valid_d;
  logic [7:0]  glyph_code_q, glyph_code_d;
  logic [31:0] out_color_q;
  logic        end_flag_q;

  logic         in_fire;
  named_color_t named;
  hex_digit_t   digit;

  // The input side advances whenever the output register is free or drains now.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  assign named = named_color(in_i.char_code);
  assign digit = hex_digit(in_i.char_code);

  // Parse one character against the current phase.
  always_comb begin
    phase_d       = phase_q;
    color_d       = color_q;
    acc_d         = acc_q;
    glyph_valid_d = 1'b0;
    glyph_code_d  = 8'h00;
    unique case (phase_q)
      PhasePlain: begin
        if (in_i.char_code == CharCaret) begin
          phase_d = PhaseEscape;
        end else begin
          glyph_valid_d = 1'b1;
          glyph_code_d  = in_i.char_code;
        end
      end
      PhaseEscape: begin
        if (in_i.char_code == CharCaret) begin
          glyph_valid_d = 1'b1;
          glyph_code_d  = in_i.char_code;
        end else if (named.hit) begin
          color_d = named.rgba;
          phase_d = PhasePlain;
        end else if (in_i.char_code == CharBracket) begin
          acc_d   = 32'h0000_0000;
          phase_d = PhaseDigits;
        end else begin
          glyph_valid_d = 1'b1;
          glyph_code_d  = in_i.char_code;
          phase_d       = PhasePlain;
        end
      end
      PhaseDigits: begin
        if (in_i.char_code == CharClose) begin
          color_d = acc_q;
          phase_d = PhasePlain;
        end else if (digit.hit) begin
          acc_d = {acc_q[27:0], digit.value};
        end else begin
          phase_d = PhaseSkip;
        end
      end
      PhaseSkip: begin
        if (in_i.char_code == CharClose) begin
          color_d = acc_q;
          phase_d = PhasePlain;
        end
      end
      default: begin
        phase_d = PhasePlain;
      end
    endcase
  end

  // Parser state; a configuration write reloads both default and current color.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhasePlain;
      color_q   <= ColorResetValue;
      acc_q     <= 32'h0000_0000;
      default_q <= ColorResetValue;
    end else if (cfg_we_i) begin
      default_q <= cfg_wdata_i;
      color_q   <= cfg_wdata_i;
    end else if (in_fire) begin
      if (in_i.text_end) begin
        phase_q <= PhasePlain;
        color_q <= default_q;
        acc_q   <= 32'h0000_0000;
      end else begin
        phase_q <= phase_d;
        color_q <= color_d;
        acc_q   <= acc_d;
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  // Output payload, loaded with each accepted beat.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      glyph_valid_q <= glyph_valid_d;
      glyph_code_q  <= glyph_code_d;
      out_color_q   <= color_d;
      end_flag_q    <= in_i.text_end;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.glyph_valid = glyph_valid_q;
  assign out_o.glyph_code  = glyph_code_q;
  assign out_o.red         = out_color_q[31:24];
  assign out_o.green       = out_color_q[23:16];
  assign out_o.blue        = out_color_q[15:8];
  assign out_o.alpha       = out_color_q[7:0];
  assign out_o.end_flag    = end_flag_q;

endmodule

`default_nettype wire

// ===== dv/tb_text_color_markup_parser_core.sv =====
// Testbench for the caret color markup parser: directed and random text against a glyph predictor.
`timescale 1ns / 1ps

module tb_text_color_markup_parser_core;
  import tcm_pkg::*;

  localparam int    WatchdogLimit = 3000;
  localparam int    LongHoldCycles = 250;
  localparam int    PhaseCount = 6;
  localparam int    PhaseChars = 115;
  localparam string HexChars = "0123456789abcdefABCDEF";
  localparam string ColorLetters = "rgbcymkw";

  typedef logic [7:0] char_t;

  typedef enum logic [1:0] {
    PhasePlain,
    PhaseEscape,
    PhaseDigits,
    PhaseSkip
  } parse_phase_e;

  typedef enum int {
    IdleNone,
    IdleLight,
    IdleHeavy
  } idle_mode_e;

  // One output beat as the receiver sees it.
  typedef struct packed {
    logic       glyph_valid;
    logic [7:0] glyph_code;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       end_flag;
  } glyph_t;

  // Predicts the glyph of each accepted character and checks the output beats in order.
  class glyph_scoreboard;
    glyph_t       expected_q[$];
    int           errors;
    int           checked;
    parse_phase_e phase;
    logic [31:0]  cur_color;
    logic [31:0]  hex_acc;
    logic [31:0]  default_color;

    function new();
      errors        = 0;
      checked       = 0;
      phase         = PhasePlain;
      cur_color     = ColorResetValue;
      hex_acc       = '0;
      default_color = ColorResetValue;
    endfunction

    // A default color write takes effect on the current color at once.
    function void write_default(logic [31:0] value);
      default_color = value;
      cur_color     = value;
    endfunction

    function bit lookup_named(char_t ch, output logic [31:0] rgba);
      lookup_named = 1'b1;
      case (ch)
        "r":     rgba = 32'hFF00_00FF;
        "g":     rgba = 32'h00FF_00FF;
        "b":     rgba = 32'h0000_FFFF;
        "c":     rgba = 32'h00FF_FFFF;
        "y":     rgba = 32'hFFFF_00FF;
        "m":     rgba = 32'hFF00_FFFF;
        "k":     rgba = 32'h0000_00FF;
        "w":     rgba = 32'hFFFF_FFFF;
        default: begin
          rgba         = '0;
          lookup_named = 1'b0;
        end
      endcase
    endfunction

    function bit decode_hex(char_t ch, output logic [3:0] nibble);
      decode_hex = 1'b1;
      nibble     = '0;
      if (ch >= "0" && ch <= "9") begin
        nibble = 4'(ch - "0");
      end else if (ch >= "a" && ch <= "f") begin
        nibble = 4'(ch - "a" + 8'd10);
      end else if (ch >= "A" && ch <= "F") begin
        nibble = 4'(ch - "A" + 8'd10);
      end else begin
        decode_hex = 1'b0;
      end
    endfunction

    // Advances the parse state by one character and queues the glyph it yields.
    function void note_char(char_t ch, logic last);
      glyph_t      res;
      logic [31:0] rgba;
      logic [3:0]  nibble;
      res          = '0;
      res.end_flag = last;
      case (phase)
        PhasePlain: begin
          if (ch == CharCaret) begin
            phase = PhaseEscape;
          end else begin
            res.glyph_valid = 1'b1;
            res.glyph_code  = ch;
          end
        end
        PhaseEscape: begin
          if (ch == CharCaret) begin
            res.glyph_valid = 1'b1;
            res.glyph_code  = ch;
          end else if (lookup_named(ch, rgba)) begin
            cur_color = rgba;
            phase     = PhasePlain;
          end else if (ch == CharBracket) begin
            hex_acc = '0;
            phase   = PhaseDigits;
          end else begin
            res.glyph_valid = 1'b1;
            res.glyph_code  = ch;
            phase           = PhasePlain;
          end
        end
        PhaseDigits: begin
          if (ch == CharClose) begin
            cur_color = hex_acc;
            phase     = PhasePlain;
          end else if (decode_hex(ch, nibble)) begin
            hex_acc = {hex_acc[27:0], nibble};
          end else begin
            phase = PhaseSkip;
          end
        end
        default: begin
          if (ch == CharClose) begin
            cur_color = hex_acc;
            phase     = PhasePlain;
          end
        end
      endcase
      {res.red, res.green, res.blue, res.alpha} = cur_color;
      // End of text goes back to plain text and the default color.
      if (last) begin
        phase     = PhasePlain;
        cur_color = default_color;
        hex_acc   = '0;
      end
      expected_q = {expected_q, res};
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, int got, int want);
      if (got != want) begin
        report($sformatf("beat %0d %s got 0x%0h want 0x%0h", checked, name, got, want));
      end
    endtask

    // Compares one output beat against the oldest prediction.
    task check_glyph(glyph_t got);
      glyph_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected output beat 0x%0h", got));
      end else begin
        want = expected_q.pop_front();
        compare_field("glyph_valid", got.glyph_valid, want.glyph_valid);
        compare_field("glyph_code", got.glyph_code, want.glyph_code);
        compare_field("red", got.red, want.red);
        compare_field("green", got.green, want.green);
        compare_field("blue", got.blue, want.blue);
        compare_field("alpha", got.alpha, want.alpha);
        compare_field("end_flag", got.end_flag, want.end_flag);
      end
      checked++;
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  tcm_in_if  in_if ();
  tcm_out_if out_if ();

  glyph_scoreboard sb;
  char_t           text_q[$];
  idle_mode_e      send_mode;
  idle_mode_e      recv_mode;
  bit              hold_req;

  text_color_markup_parser_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Gap length for one side: mostly none or short, now and then long.
  function automatic int gap_len(idle_mode_e mode);
    if (mode == IdleNone) return 0;
    if ($urandom_range(0, 3) >= int'(mode)) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Appends one character to the text buffer.
  function void add_char(char_t ch);
    text_q = {text_q, ch};
  endfunction

  // Offers one character beat and waits until the block takes it.
  task send_char(char_t ch, logic last);
    int gap;
    gap = gap_len(send_mode);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.char_code <= ch;
    in_if.text_end  <= last;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_char(ch, last);
  endtask

  // Sends the buffered text; the final character carries the end mark if asked.
  task send_text(bit with_end);
    for (int i = 0; i < text_q.size(); i++) begin
      send_char(text_q[i], with_end && (i == text_q.size() - 1));
    end
    text_q.delete();
  endtask

  task send_string(string s, bit with_end);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
    send_text(with_end);
  endtask

  // Appends one markup token, mostly well formed, sometimes noise.
  function void add_token();
    int    kind;
    int    n;
    char_t ch;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin
        ch = char_t'($urandom_range(32, 126));
        if (ch == CharCaret) ch = "_";
        add_char(ch);
      end
      4: begin
        add_char(CharCaret);
        add_char(ColorLetters[$urandom_range(0, 7)]);
      end
      5, 6: begin
        // Hex color: up to ten digits, optional junk, usually closed.
        add_char(CharCaret);
        add_char(CharBracket);
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++) add_char(HexChars[$urandom_range(0, 21)]);
        if ($urandom_range(0, 2) == 0) begin
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++) begin
            ch = char_t'($urandom_range(0, 255));
            add_char(ch == CharClose ? 8'h00 : ch);
          end
        end
        if ($urandom_range(0, 7) != 0) add_char(CharClose);
      end
      7: begin
        n = $urandom_range(2, 4);
        for (int i = 0; i < n; i++) add_char(CharCaret);
      end
      8: begin
        add_char(CharCaret);
        add_char(char_t'($urandom_range(0, 255)));
      end
      default: begin
        add_char(char_t'($urandom_range(0, 255)));
      end
    endcase
  endfunction

  // Builds one text; a few are cut short so they can end inside a sequence.
  function void build_text();
    int ntok;
    int keep;
    ntok = $urandom_range(1, 8);
    for (int i = 0; i < ntok; i++) add_token();
    if ($urandom_range(0, 5) == 0) begin
      keep   = $urandom_range(1, text_q.size());
      text_q = text_q[0:keep-1];
    end
  endfunction

  // Sends random texts until enough characters went in.
  task run_phase(int n_chars, bit leave_open);
    int sent;
    sent = 0;
    while (sent < n_chars) begin
      build_text();
      sent += text_q.size();
      send_text(1'b1);
    end
    // A text left open lets the next register write land in the middle of it.
    if (leave_open) send_string($urandom_range(0, 1) ? "x^" : "^[3", 1'b0);
  endtask

  // Waits until every predicted beat has come out and the block has settled.
  task wait_drained();
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task write_default_color(logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.write_default(value);
  endtask

  // Receiver: takes output beats with random stalls and an optional long hold.
  initial begin
    int stall;
    stall        = 0;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        sb.check_glyph({out_if.glyph_valid, out_if.glyph_code, out_if.red, out_if.green,
                        out_if.blue, out_if.alpha, out_if.end_flag});
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = LongHoldCycles;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
        stall = gap_len(recv_mode);
      end
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
    end
    $display("[%0t] watchdog: no beat moved for %0d cycles", $time, WatchdogLimit);
    $display("end of test: mismatches");
    $finish;
  end

  // Main sequence: reset, directed text, then random phases under several default colors.
  initial begin
    sb              = new();
    send_mode       = IdleNone;
    recv_mode       = IdleNone;
    hold_req        = 1'b0;
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.char_code = '0;
    in_if.text_end  = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: byte extremes, escapes, empty and unclosed brackets, trailing caret.
    send_mode = IdleLight;
    recv_mode = IdleLight;
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_string("A^rQ^^^?^[]Z^[1aF9xz]y^[7", 1'b1);
    send_string("^", 1'b1);
    send_string("C^", 1'b0);

    for (int p = 0; p < PhaseCount; p++) begin
      wait_drained();
      send_mode = idle_mode_e'($urandom_range(0, 2));
      recv_mode = idle_mode_e'($urandom_range(0, 2));
      case (p)
        0:       write_default_color(32'h0000_0000);
        1:       write_default_color(32'hFFFF_FFFF);
        default: write_default_color($urandom());
      endcase
      // One phase keeps the sender busy while the receiver holds off.
      if (p == 2) begin
        send_mode = IdleNone;
        hold_req  = 1'b1;
      end
      run_phase(PhaseChars, p != PhaseCount - 1);
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (sb.expected_q.size() != 0) begin
      sb.report($sformatf("%0d predicted beats never came out", sb.expected_q.size()));
    end
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
